/* rtl/psg_register_log_decoder_assert.svh */
// Assertion macros for the sound-chip register log decoder checker.
// Needs a clock and an active-low reset name passed in at each use.
`ifndef PSG_REGISTER_LOG_DECODER_ASSERT_SVH
`define PSG_REGISTER_LOG_DECODER_ASSERT_SVH

// Same-cycle implication.
`define PRLD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prld assertion failed");

// Next-cycle implication.
`define PRLD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prld assertion failed");

`endif

/* rtl/prld_pkg.sv */
// Shared types and constants of the register log decoder.
// No dependencies; every file but the assertion macros header imports this package.
package prld_pkg;

  localparam int BYTE_W       = 8;
  localparam int REG_IDX_W    = 4;
  localparam int WORD_W       = 64;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int HEADER_BYTES = 8;
  localparam int HDR_CNT_W    = 3;
  localparam int SHADOW_DEPTH = 16;
  localparam int SHADOW_IDX_W = 4;
  localparam int SNAPSHOT_REGS = 14;
  localparam int AMT_W        = 12;
  localparam int DELAY_STEP   = 12;

  localparam logic [SHADOW_IDX_W-1:0] SNAP_LAST = SHADOW_IDX_W'(SNAPSHOT_REGS - 1);
  localparam logic [HDR_CNT_W-1:0]    HDR_LAST  = HDR_CNT_W'(HEADER_BYTES - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_TIME       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD      = 2'd2;

  // Command opcodes (high nibble of the first command byte)
  localparam logic [3:0] OP_REGWRITE  = 4'h0;
  localparam logic [3:0] OP_DELAY_LO  = 4'h1;
  localparam logic [3:0] OP_DELAY_MID = 4'h2;
  localparam logic [3:0] OP_DELAY_HI  = 4'h3;
  localparam logic [3:0] OP_TEXT      = 4'h8;
  localparam logic [3:0] OP_END       = 4'hf;

  localparam logic [BYTE_W-1:0] END_PROPER_BYTE = 8'hff;

  typedef enum logic [2:0] {
    KIND_REGWRITE  = 3'd0,
    KIND_DELAY     = 3'd1,
    KIND_MARKSTART = 3'd2,
    KIND_MARKREG   = 3'd3,
    KIND_TEXTSTART = 3'd4,
    KIND_TEXTBYTE  = 3'd5,
    KIND_STOP      = 3'd6,
    KIND_ERROR     = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ERR_BAD_MAGIC    = 3'd0,
    ERR_BAD_VERSION  = 3'd1,
    ERR_PREMATURE    = 3'd2,
    ERR_TEXT_CUT     = 3'd3,
    ERR_SHORT_HEADER = 3'd4
  } err_t;

  // Controller to datapath
  typedef struct packed {
    logic  hdr_shift;
    logic  latch_first;
    logic  latch_byte;
    logic  add_delay;
    logic  eval;
    logic  snap_clr;
    logic  snap_inc;
    logic  flush;
    logic  shadow_wr;
    logic  text_load;
    logic  text_dec;
    logic  emit;
    kind_t kind;
    err_t  err;
    logic  last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       hdr_last;
    logic       magic_ok;
    logic       ver_ok;
    logic [3:0] op;
    logic       byte_nonzero;
    logic       text_zero;
    logic       mark_hit;
    logic       flush_hit;
    logic       snap_last;
    logic       out_free;
  } dp_stat_t;

endpackage

/* rtl/prld_in_if.sv */
// Input byte channel of the register log decoder.
// Depends on prld_pkg for widths.
interface prld_in_if;
  import prld_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

/* rtl/prld_out_if.sv */
// Result channel of the register log decoder.
// Depends on prld_pkg for widths.
interface prld_out_if;
  import prld_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [2:0]           kind;
  logic [REG_IDX_W-1:0] reg_index;
  logic [BYTE_W-1:0]    data_value;
  logic [WORD_W-1:0]    amount;
  logic [WORD_W-1:0]    running_total;
  logic [2:0]           error_code;
  logic                 last_of_run;

  modport source (output valid, output kind, output reg_index, output data_value,
                  output amount, output running_total, output error_code,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input reg_index, input data_value,
                  input amount, input running_total, input error_code,
                  input last_of_run, output ready);
endinterface

/* rtl/psg_register_log_decoder.sv */
// Header bytes are shifted in, then a check state follows the eighth; delay and
// unknown commands emit no result, text and end commands emit one, as does each text byte.
// A register write emits its result after any mark snapshot and delay flush results, as
// the controller emits one result per cycle into the single output register while it is free.
// Results are registered. Reset (rst_n, synchronous)
// clears config, parse state, accumulators and the register shadow to zero.
module psg_register_log_decoder import prld_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  prld_in_if.sink               in_ch,
  prld_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t            cmd;
  dp_stat_t             stat;
  logic                 in_ready;
  kind_t                dp_kind;
  err_t                 dp_err;
  logic                 dp_valid;
  logic [REG_IDX_W-1:0] dp_reg;
  logic [BYTE_W-1:0]    dp_data;
  logic [WORD_W-1:0]    dp_amount;
  logic [WORD_W-1:0]    dp_total;
  logic                 dp_last;

  prld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_eos   (in_ch.end_of_stream),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  prld_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_byte           (in_ch.in_byte),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .stat              (stat),
    .out_ready         (out_ch.ready),
    .out_valid         (dp_valid),
    .out_kind          (dp_kind),
    .out_reg_index     (dp_reg),
    .out_data_value    (dp_data),
    .out_amount        (dp_amount),
    .out_running_total (dp_total),
    .out_error_code    (dp_err),
    .out_last          (dp_last)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = dp_valid;
  assign out_ch.kind          = dp_kind;
  assign out_ch.reg_index     = dp_reg;
  assign out_ch.data_value    = dp_data;
  assign out_ch.amount        = dp_amount;
  assign out_ch.running_total = dp_total;
  assign out_ch.error_code    = dp_err;
  assign out_ch.last_of_run   = dp_last;

endmodule

/* rtl/prld_dp.sv */
// Datapath: config registers, header shifter, delay/time accumulators,
// register shadow, text counter and the result output register. Uses prld_pkg.
module prld_dp import prld_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [BYTE_W-1:0]     in_byte,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output kind_t                 out_kind,
  output logic [REG_IDX_W-1:0]  out_reg_index,
  output logic [BYTE_W-1:0]     out_data_value,
  output logic [WORD_W-1:0]     out_amount,
  output logic [WORD_W-1:0]     out_running_total,
  output err_t                  out_error_code,
  output logic                  out_last
);

  logic [CFG_DATA_W-1:0]   thresh_r;
  logic [CFG_DATA_W-1:0]   mark_r;
  logic [CFG_DATA_W-1:0]   magic_r;
  logic [WORD_W-1:0]       hdr_shift_r;
  logic [HDR_CNT_W-1:0]    hdr_cnt_r;
  logic [BYTE_W-1:0]       first_r;
  logic [BYTE_W-1:0]       byte_r;
  logic [WORD_W-1:0]       delay_r;
  logic [WORD_W-1:0]       total_r;
  logic [BYTE_W-1:0]       shadow_r [SHADOW_DEPTH];
  logic [BYTE_W-1:0]       text_left_r;
  logic [SHADOW_IDX_W-1:0] snap_r;
  logic                    mark_hit_r;
  logic                    flush_hit_r;
  logic                    out_valid_r;
  kind_t                   out_kind_r;
  logic [REG_IDX_W-1:0]    out_reg_r;
  logic [BYTE_W-1:0]       out_data_r;
  logic [WORD_W-1:0]       out_amount_r;
  logic [WORD_W-1:0]       out_total_r;
  err_t                    out_err_r;
  logic                    out_last_r;

  logic [WORD_W-1:0]    sum;
  logic [WORD_W-1:0]    mark_ext;
  logic [AMT_W-1:0]     amt12;
  logic [WORD_W-1:0]    delay_add;
  logic [REG_IDX_W-1:0] ld_reg;
  logic [BYTE_W-1:0]    ld_data;
  logic [WORD_W-1:0]    ld_amount;
  logic [WORD_W-1:0]    ld_total;
  err_t                 ld_err;
  logic                 proper_end;

  // One shared adder: mark check and delay flush both want total + delay
  assign sum      = total_r + delay_r;
  assign mark_ext = {{(WORD_W-CFG_DATA_W){1'b0}}, mark_r};
  assign amt12    = {first_r[REG_IDX_W-1:0], in_byte};
  assign proper_end = (first_r == END_PROPER_BYTE) && (byte_r == END_PROPER_BYTE);

  always_comb begin
    unique case (first_r[7:4])
      OP_DELAY_LO:  delay_add = WORD_W'(amt12);
      OP_DELAY_MID: delay_add = WORD_W'(amt12) << DELAY_STEP;
      OP_DELAY_HI:  delay_add = WORD_W'(amt12) << (2 * DELAY_STEP);
      default:      delay_add = '0;
    endcase
  end

  always_comb begin
    ld_reg    = '0;
    ld_data   = '0;
    ld_amount = '0;
    ld_total  = '0;
    ld_err    = ERR_BAD_MAGIC;
    unique case (cmd.kind)
      KIND_REGWRITE: begin
        ld_reg  = first_r[REG_IDX_W-1:0];
        ld_data = byte_r;
      end
      KIND_DELAY: begin
        ld_amount = delay_r;
        ld_total  = sum;
      end
      KIND_MARKSTART: ld_amount = mark_ext;
      KIND_MARKREG: begin
        ld_reg  = snap_r;
        ld_data = shadow_r[snap_r];
      end
      KIND_TEXTSTART: begin
        ld_reg  = first_r[REG_IDX_W-1:0];
        ld_data = byte_r;
      end
      KIND_TEXTBYTE: ld_data = byte_r;
      KIND_STOP:     ld_data = BYTE_W'(proper_end);
      KIND_ERROR:    ld_err  = cmd.err;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= '0;
      mark_r      <= '0;
      magic_r     <= '0;
      hdr_shift_r <= '0;
      hdr_cnt_r   <= '0;
      delay_r     <= '0;
      total_r     <= '0;
      for (int i = 0; i < SHADOW_DEPTH; i++) shadow_r[i] <= '0;
      text_left_r <= '0;
      snap_r      <= '0;
      mark_hit_r  <= 1'b0;
      flush_hit_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FLUSH_THRESHOLD: thresh_r <= cfg_wdata;
          CFG_MARK_TIME:       mark_r   <= cfg_wdata;
          CFG_MAGIC_WORD:      magic_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.hdr_shift) begin
        hdr_shift_r <= {hdr_shift_r[WORD_W-BYTE_W-1:0], in_byte};
        hdr_cnt_r   <= hdr_cnt_r + HDR_CNT_W'(1);
      end
      if (cmd.eval) begin
        mark_hit_r  <= (mark_r != '0) && (total_r <= mark_ext) && (sum > mark_ext);
        flush_hit_r <= (delay_r != '0) &&
                       (delay_r >= {{(WORD_W-CFG_DATA_W){1'b0}}, thresh_r});
      end
      if (cmd.flush) begin
        total_r <= sum;
        delay_r <= '0;
      end else if (cmd.add_delay) begin
        delay_r <= delay_r + delay_add;
      end
      if (cmd.shadow_wr) shadow_r[first_r[REG_IDX_W-1:0]] <= byte_r;
      if (cmd.text_load) begin
        text_left_r <= byte_r;
      end else if (cmd.text_dec && text_left_r != '0) begin
        text_left_r <= text_left_r - BYTE_W'(1);
      end
      if (cmd.snap_clr) begin
        snap_r <= '0;
      end else if (cmd.snap_inc) begin
        snap_r <= snap_r + SHADOW_IDX_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.latch_first) first_r <= in_byte;
    if (cmd.latch_byte)  byte_r  <= in_byte;
    if (cmd.emit) begin
      out_kind_r   <= cmd.kind;
      out_reg_r    <= ld_reg;
      out_data_r   <= ld_data;
      out_amount_r <= ld_amount;
      out_total_r  <= ld_total;
      out_err_r    <= ld_err;
      out_last_r   <= cmd.last;
    end
  end

  always_comb begin
    stat.hdr_last     = (hdr_cnt_r == HDR_LAST);
    stat.magic_ok     = (hdr_shift_r[WORD_W-1:CFG_DATA_W] == magic_r);
    stat.ver_ok       = (hdr_shift_r[CFG_DATA_W-1:0] == '0);
    stat.op           = first_r[7:4];
    stat.byte_nonzero = (byte_r != '0);
    stat.text_zero    = (text_left_r == '0);
    stat.mark_hit     = mark_hit_r;
    stat.flush_hit    = flush_hit_r;
    stat.snap_last    = (snap_r == SNAP_LAST);
    stat.out_free     = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_reg_index     = out_reg_r;
  assign out_data_value    = out_data_r;
  assign out_amount        = out_amount_r;
  assign out_running_total = out_total_r;
  assign out_error_code    = out_err_r;
  assign out_last          = out_last_r;

endmodule

/* rtl/prld_ctrl.sv */
// Controller state machine: parse phase tracking and result sequencing.
// Drives datapath commands; uses prld_pkg.
module prld_ctrl import prld_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_eos,
  input  dp_stat_t  stat,
  output logic      in_ready,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_HDR, ST_HCHK, ST_CMD1, ST_CMD2, ST_EVAL, ST_MARK, ST_SNAP, ST_FLUSH,
    ST_WRITE, ST_TSTART, ST_TEXT, ST_TBYTE, ST_STOP, ST_ERR, ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  err_t   err_r, err_nxt;

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_HDR: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_eos) begin
            err_nxt   = ERR_SHORT_HEADER;
            state_nxt = ST_ERR;
          end else begin
            cmd.hdr_shift = 1'b1;
            if (stat.hdr_last) state_nxt = ST_HCHK;
          end
        end
      end
      ST_HCHK: begin
        // magic word takes precedence over version
        priority if (!stat.magic_ok) begin
          err_nxt   = ERR_BAD_MAGIC;
          state_nxt = ST_ERR;
        end else if (!stat.ver_ok) begin
          err_nxt   = ERR_BAD_VERSION;
          state_nxt = ST_ERR;
        end else begin
          state_nxt = ST_CMD1;
        end
      end
      ST_CMD1: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_eos) begin
            err_nxt   = ERR_PREMATURE;
            state_nxt = ST_ERR;
          end else begin
            cmd.latch_first = 1'b1;
            state_nxt       = ST_CMD2;
          end
        end
      end
      ST_CMD2: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_eos) begin
            err_nxt   = ERR_PREMATURE;
            state_nxt = ST_ERR;
          end else begin
            cmd.latch_byte = 1'b1;
            unique case (stat.op)
              OP_REGWRITE: state_nxt = ST_EVAL;
              OP_DELAY_LO, OP_DELAY_MID, OP_DELAY_HI: begin
                cmd.add_delay = 1'b1;
                state_nxt     = ST_CMD1;
              end
              OP_TEXT: state_nxt = ST_TSTART;
              OP_END:  state_nxt = ST_STOP;
              default: state_nxt = ST_CMD1;
            endcase
          end
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_MARK;
      end
      ST_MARK: begin
        if (!stat.mark_hit) begin
          state_nxt = ST_FLUSH;
        end else if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.kind     = KIND_MARKSTART;
          cmd.snap_clr = 1'b1;
          state_nxt    = ST_SNAP;
        end
      end
      ST_SNAP: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_MARKREG;
          if (stat.snap_last) state_nxt = ST_FLUSH;
          else cmd.snap_inc = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!stat.flush_hit) begin
          state_nxt = ST_WRITE;
        end else if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_DELAY;
          cmd.flush = 1'b1;
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = KIND_REGWRITE;
          cmd.last      = 1'b1;
          cmd.shadow_wr = 1'b1;
          state_nxt     = ST_CMD1;
        end
      end
      ST_TSTART: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = KIND_TEXTSTART;
          cmd.last      = 1'b1;
          cmd.text_load = 1'b1;
          state_nxt     = stat.byte_nonzero ? ST_TEXT : ST_CMD1;
        end
      end
      ST_TEXT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_eos) begin
            err_nxt   = ERR_TEXT_CUT;
            state_nxt = ST_ERR;
          end else begin
            cmd.latch_byte = 1'b1;
            cmd.text_dec   = 1'b1;
            state_nxt      = ST_TBYTE;
          end
        end
      end
      ST_TBYTE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_TEXTBYTE;
          cmd.last  = 1'b1;
          state_nxt = stat.text_zero ? ST_CMD1 : ST_TEXT;
        end
      end
      ST_STOP: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_STOP;
          cmd.last  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_ERROR;
          cmd.err   = err_r;
          cmd.last  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // drop everything after a stop or error
        in_ready = 1'b1;
      end
      default: state_nxt = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HDR;
      err_r   <= ERR_BAD_MAGIC;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

/* rtl/prld_checker.sv */
// Port-level checks on the decoder's result channel, bound to the top level.
// Uses prld_pkg and the assertion macros header.
`include "psg_register_log_decoder_assert.svh"

module prld_checker import prld_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_data_value,
  input logic [63:0] out_amount,
  input logic [2:0]  out_error_code,
  input logic        out_last
);

  // stalled result holds
  `PRLD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_data_value) && $stable(out_amount))

  // stop and error always close a run
  `PRLD_ASSERT_IMP(a_end_last, clk, rst_n, out_valid && (out_kind == KIND_ERROR || out_kind == KIND_STOP), out_last)

  // snapshot and flush results never close a run, as the register write follows them
  `PRLD_ASSERT_IMP(a_mid_run, clk, rst_n, out_valid && (out_kind == KIND_MARKSTART || out_kind == KIND_MARKREG || out_kind == KIND_DELAY), !out_last)

  `PRLD_ASSERT_IMP(a_err_code, clk, rst_n, out_valid && out_kind != KIND_ERROR, out_error_code == '0)

endmodule

bind psg_register_log_decoder prld_checker u_prld_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_data_value (out_ch.data_value),
  .out_amount     (out_ch.amount),
  .out_error_code (out_ch.error_code),
  .out_last       (out_ch.last_of_run)
);
